// File: hw/rtl/fbsp_pkg.sv
// Shared types and constants for the FAT boot sector parser.
package fbsp_pkg;

    localparam logic [3:0] TAG_STATUS   = 4'd0;
    localparam logic [3:0] TAG_TYPE     = 4'd1;
    localparam logic [3:0] TAG_CLUS     = 4'd2;
    localparam logic [3:0] TAG_FATS     = 4'd3;
    localparam logic [3:0] TAG_FAT_LBA  = 4'd4;
    localparam logic [3:0] TAG_FAT_SIZE = 4'd5;
    localparam logic [3:0] TAG_ROOT_LBA = 4'd6;
    localparam logic [3:0] TAG_ROOT_SEC = 4'd7;
    localparam logic [3:0] TAG_DATA_LBA = 4'd8;
    localparam logic [3:0] TAG_CLUSTERS = 4'd9;
    localparam logic [3:0] TAG_ROOT_CLU = 4'd10;
    localparam logic [3:0] TAG_FSINFO   = 4'd11;
    localparam logic [3:0] TAG_LBL_LEN  = 4'd12;
    localparam logic [3:0] TAG_LBL_CHR  = 4'd13;

    localparam logic [31:0] ST_OK     = 32'd0;
    localparam logic [31:0] ST_SIG    = 32'd1;
    localparam logic [31:0] ST_FIELDS = 32'd2;
    localparam logic [31:0] ST_ZERO   = 32'd3;
    localparam logic [31:0] ST_NODATA = 32'd4;

    localparam int LABEL_LEN = 11;

    typedef struct packed {
        logic       start;
        logic [7:0] divisor;
        logic [33:0] dividend;
    } fbsp_div_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] quotient;
    } fbsp_div_rsp_t;

endpackage

// File: hw/rtl/fbsp_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module fbsp_divider
    import fbsp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  fbsp_div_req_t req,
    output fbsp_div_rsp_t rsp
);

    logic [33:0] quo_reg, quo_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[7:0], quo_reg[33]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[32:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: hw/rtl/fat_boot_sector_parser.sv
// Top level of the FAT boot sector parser: capture, checks, sequencer, output.
//
// Usage:
//   s_axis carries one boot sector byte per beat, offsets 0..511 in order.
//   Offsets 0..510 are taken one per cycle and produce nothing.
//   The beat at offset 511 starts the result run; s_axis_tready stays low
//   until the last result beat has been loaded into the output register.
//   m_axis carries the results: tdata = {word, tag}, tlast marks the end.
//   An error gives a single status beat with tlast set.
//   On success: status, type, cluster size, FAT copies, FAT start, FAT size,
//   root start, root sectors, data start, cluster count, for FAT32 the
//   root cluster and info sector, then label length and label chars.
// Sequence: the edge that takes byte 511 starts the 8x32 multiply, two adds
//   on the shared 40-bit adder and the check, then a subtract on the same
//   adder, the 34-step divide and its done flag, the label step and the load
//   into the output register. On an error the check goes straight to the
//   output register. Then one beat per cycle while m_axis is ready. Input
//   stays blocked for the whole run, on an error as well.
// Stall: a stalled m_axis holds its beat and the sequencer waits.
// Reset (aresetn low, synchronous) returns the byte offset to zero and
//   idles the sequencer; the captured fields are rewritten by the next sector.
module fat_boot_sector_parser
    import fbsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] tag, [35:4] word, [39:36] zero
    output logic        m_axis_tlast    // final_res
);

    localparam logic [3:0] S_CAP   = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ADD1  = 4'd2;
    localparam logic [3:0] S_ADD2  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SUB   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_LBL   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // FAT type codes held in type_reg
    localparam logic [1:0] FT_12 = 2'd0;
    localparam logic [1:0] FT_16 = 2'd1;
    localparam logic [1:0] FT_32 = 2'd2;

    logic [8:0]  pos_reg;
    logic [3:0]  state_reg, state_next;
    logic [7:0]  sig_reg, sig2_reg, clus_reg, fats_reg;
    logic [15:0] bps_reg, rsv_reg, rent_reg, tots_reg, fszs_reg, info_reg;
    logic [31:0] totl_reg, fszl_reg, rclu_reg;
    logic [7:0]  lbl_s_reg [LABEL_LEN];
    logic [7:0]  lbl_l_reg [LABEL_LEN];

    // arithmetic results, wide enough that no start sector wraps
    logic [39:0] acc_reg, acc_next;     // multiply product; shared adder output
    logic [39:0] dir_start_reg, heap_start_reg;
    logic [33:0] clusters_reg;
    logic [31:0] status_reg;
    logic [1:0]  type_reg;
    logic [3:0]  len_reg;
    logic [3:0]  tag_reg;
    logic [3:0]  ci_reg;
    logic        ovalid_reg;
    logic [3:0]  otag_reg;
    logic [31:0] oword_reg;
    logic        olast_reg;

    logic [31:0] fat_sz, tot;
    logic [12:0] dir_secs;
    logic        accept, last_byte;
    logic [39:0] add_a, add_b;
    logic        is32;
    logic [7:0]  area [LABEL_LEN];
    logic [3:0]  lbl_len;
    logic [31:0] emit_word;
    logic [7:0]  ch;
    logic        out_free;
    logic [31:0] status_next_w;
    logic        emit_last;
    logic [3:0]  tag_after;

    fbsp_div_req_t div_req;
    fbsp_div_rsp_t div_rsp;

    fbsp_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign fat_sz    = (fszs_reg != 16'd0) ? {16'd0, fszs_reg} : fszl_reg;
    assign tot       = (tots_reg != 16'd0) ? {16'd0, tots_reg} : totl_reg;
    // (entries*32 + 511)/512 = ceil(entries/16), at most 4096
    assign dir_secs  = 13'(({1'b0, rent_reg} + 17'd15) >> 4);
    assign is32      = (type_reg == FT_32);

    assign s_axis_tready = (state_reg == S_CAP);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign last_byte     = accept && (pos_reg == 9'd511);

    // shared adder operand select
    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            S_ADD1:  begin add_a = {24'd0, rsv_reg}; add_b = acc_reg; end
            S_ADD2:  begin add_a = dir_start_reg; add_b = {27'd0, dir_secs}; end
            S_SUB:   begin add_a = {8'd0, tot}; add_b = ~heap_start_reg + 40'd1; end
            default: begin add_a = '0; add_b = '0; end
        endcase
    end

    always_comb begin
        for (int i = 0; i < LABEL_LEN; i++) area[i] = is32 ? lbl_l_reg[i] : lbl_s_reg[i];
    end

    // label length: trailing spaces cut, then first zero
    always_comb begin
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < LABEL_LEN; i++) if (area[i] != 8'h20) n = 4'(i + 1);
        lbl_len = n;
        for (int i = LABEL_LEN - 1; i >= 0; i--)
            if (area[i] == 8'h00 && 4'(i) < n) lbl_len = 4'(i);
    end

    always_comb begin
        ch = area[ci_reg];
        if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
        unique case (tag_reg)
            TAG_STATUS:   emit_word = status_reg;
            TAG_TYPE:     emit_word = (type_reg == FT_12) ? 32'd12 :
                                      (type_reg == FT_16) ? 32'd16 : 32'd32;
            TAG_CLUS:     emit_word = {24'd0, clus_reg};
            TAG_FATS:     emit_word = {24'd0, fats_reg};
            TAG_FAT_LBA:  emit_word = {16'd0, rsv_reg};
            TAG_FAT_SIZE: emit_word = fat_sz;
            TAG_ROOT_LBA: emit_word = dir_start_reg[31:0];
            TAG_ROOT_SEC: emit_word = {19'd0, dir_secs};
            TAG_DATA_LBA: emit_word = heap_start_reg[31:0];
            TAG_CLUSTERS: emit_word = clusters_reg[31:0];
            TAG_ROOT_CLU: emit_word = rclu_reg;
            TAG_FSINFO:   emit_word = {16'd0, info_reg};
            TAG_LBL_LEN:  emit_word = {28'd0, len_reg};
            TAG_LBL_CHR:  emit_word = {24'd0, ch};
            default:      emit_word = '0;
        endcase
    end

    assign out_free = !ovalid_reg || m_axis_tready;

    assign acc_next = add_a + add_b;
    // on a good sector the difference is below 2^32
    assign div_req.start    = (state_reg == S_SUB);
    assign div_req.divisor  = clus_reg;
    assign div_req.dividend = acc_next[33:0];

    // capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (pos_reg)
                9'd11: bps_reg[7:0]    <= s_axis_tdata;
                9'd12: bps_reg[15:8]   <= s_axis_tdata;
                9'd13: clus_reg        <= s_axis_tdata;
                9'd14: rsv_reg[7:0]    <= s_axis_tdata;
                9'd15: rsv_reg[15:8]   <= s_axis_tdata;
                9'd16: fats_reg        <= s_axis_tdata;
                9'd17: rent_reg[7:0]   <= s_axis_tdata;
                9'd18: rent_reg[15:8]  <= s_axis_tdata;
                9'd19: tots_reg[7:0]   <= s_axis_tdata;
                9'd20: tots_reg[15:8]  <= s_axis_tdata;
                9'd22: fszs_reg[7:0]   <= s_axis_tdata;
                9'd23: fszs_reg[15:8]  <= s_axis_tdata;
                9'd32: totl_reg[7:0]   <= s_axis_tdata;
                9'd33: totl_reg[15:8]  <= s_axis_tdata;
                9'd34: totl_reg[23:16] <= s_axis_tdata;
                9'd35: totl_reg[31:24] <= s_axis_tdata;
                9'd36: fszl_reg[7:0]   <= s_axis_tdata;
                9'd37: fszl_reg[15:8]  <= s_axis_tdata;
                9'd38: fszl_reg[23:16] <= s_axis_tdata;
                9'd39: fszl_reg[31:24] <= s_axis_tdata;
                9'd44: rclu_reg[7:0]   <= s_axis_tdata;
                9'd45: rclu_reg[15:8]  <= s_axis_tdata;
                9'd46: rclu_reg[23:16] <= s_axis_tdata;
                9'd47: rclu_reg[31:24] <= s_axis_tdata;
                9'd48: info_reg[7:0]   <= s_axis_tdata;
                9'd49: info_reg[15:8]  <= s_axis_tdata;
                9'd510: sig_reg        <= s_axis_tdata;
                9'd511: sig2_reg       <= s_axis_tdata;
                default: ;
            endcase
            for (int i = 0; i < LABEL_LEN; i++) begin
                if (pos_reg == 9'(43 + i)) lbl_s_reg[i] <= s_axis_tdata;
                if (pos_reg == 9'(71 + i)) lbl_l_reg[i] <= s_axis_tdata;
            end
        end
    end

    // status with signature first, then field rules, sizes, room for data
    always_comb begin
        priority if (sig_reg != 8'h55 || sig2_reg != 8'hAA) status_next_w = ST_SIG;
        else if (bps_reg != 16'd512 || clus_reg == 8'd0 || fats_reg == 8'd0)
            status_next_w = ST_FIELDS;
        else if (fat_sz == 32'd0 || tot == 32'd0) status_next_w = ST_ZERO;
        else if ({8'd0, tot} <= heap_start_reg) status_next_w = ST_NODATA;
        else status_next_w = ST_OK;
    end

    always_comb begin
        if (status_reg != ST_OK) emit_last = 1'b1;
        else if (tag_reg == TAG_LBL_LEN) emit_last = (len_reg == 4'd0);
        else if (tag_reg == TAG_LBL_CHR) emit_last = (ci_reg == len_reg - 4'd1);
        else emit_last = 1'b0;
    end

    always_comb begin
        if (tag_reg == TAG_CLUSTERS && !is32) tag_after = TAG_LBL_LEN;
        else if (tag_reg == TAG_LBL_CHR) tag_after = TAG_LBL_CHR;
        else tag_after = tag_reg + 4'd1;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CAP:  if (last_byte) state_next = S_MUL;
            S_MUL:  state_next = S_ADD1;
            S_ADD1: state_next = S_ADD2;
            S_ADD2: state_next = S_CHK;
            S_CHK:  state_next = (status_next_w == ST_OK) ? S_SUB : S_EMIT;
            S_SUB:  state_next = S_DIV;
            S_DIV:  if (div_rsp.done) state_next = S_LBL;
            S_LBL:  state_next = S_EMIT;
            S_EMIT: if (out_free && emit_last) state_next = S_CAP;
            default: state_next = S_CAP;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_MUL:  acc_reg <= {32'd0, fats_reg} * {8'd0, fat_sz};
            S_ADD1: dir_start_reg <= acc_next;
            S_ADD2: heap_start_reg <= acc_next;
            S_CHK:  begin status_reg <= status_next_w; tag_reg <= TAG_STATUS; end
            S_DIV:  if (div_rsp.done) begin
                        clusters_reg <= div_rsp.quotient;
                        type_reg <= (div_rsp.quotient < 34'd4085) ? FT_12 :
                                    (div_rsp.quotient < 34'd65525) ? FT_16 : FT_32;
                    end
            S_LBL:  begin len_reg <= lbl_len; ci_reg <= '0; end
            S_EMIT: if (out_free) begin
                        if (tag_reg == TAG_LBL_CHR) ci_reg <= ci_reg + 4'd1;
                        tag_reg <= tag_after;
                    end
            default: ;
        endcase
        if (state_reg == S_EMIT && out_free) begin
            otag_reg  <= tag_reg;
            oword_reg <= emit_word;
            olast_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            state_reg  <= S_CAP;
            ovalid_reg <= 1'b0;
        end else begin
            if (accept) pos_reg <= pos_reg + 9'd1;
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, oword_reg, otag_reg};
    assign m_axis_tlast  = olast_reg;

    a_no_in_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CAP) |-> !s_axis_tready) else $error("input taken while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("beat dropped");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        last_byte |=> (state_reg == S_MUL)) else $error("run not started");

endmodule

// File: sim/tb_fat_boot_sector_parser.sv
// Testbench for the FAT boot sector parser: a sector in, result beats checked.
`timescale 1ns / 100ps

module tb_fat_boot_sector_parser;
    import fbsp_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;    // about the divide and sequencer latency
    localparam int HOLD_FROM    = 496;   // offset where the long hold-off is armed
    localparam int TAIL_BYTES   = 8;     // next-sector bytes offered during the hold

    // sector flavors the generator can build
    typedef enum int {
        SK_FAT12, SK_FAT16, SK_FAT32
    } sector_kind_t;

    typedef struct {
        logic [3:0]  tag;
        logic [31:0] word;
        logic        last;
    } bpb_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    fat_boot_sector_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // sector image being built for the next send
    logic [7:0] sect [0:511];

    // predictor copy of the captured sector, filled beat by beat
    logic [7:0] cap_img [0:511];
    int         cap_pos;

    bpb_result_t bpb_expected_q[$];

    int  mismatches;
    int  bytes_sent;
    int  beats_seen;
    int  sectors_sent;
    int  cycle_count;
    bit  quiet;           // no random idling on either side while set
    logic hold_go;
    int  hold_left;
    int  rx_stall;

    //------------------------------------------------------------------
    // clock, cycle limit
    //------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, bpb_expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // receiver: random stalls per beat, plus a long hold-off on request
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= (rx_stall == 1);
        end else if (m_axis_tvalid && m_axis_tready && !quiet) begin
            int wait_n;
            wait_n = $urandom_range(0, 11);
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall      <= wait_n;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // result checker: every taken beat against the oldest expectation
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            bpb_result_t want;
            beats_seen = beats_seen + 1;
            if (bpb_expected_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected beat: tag %0d word %0d last %0b",
                             m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast);
            end else begin
                want = bpb_expected_q.pop_front();
                if (m_axis_tdata[3:0] !== want.tag || m_axis_tdata[35:4] !== want.word
                        || m_axis_tdata[39:36] !== 4'd0 || m_axis_tlast !== want.last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: expected tag %0d word %0d last %0b, got tag %0d word %0d pad %0h last %0b",
                                 want.tag, want.word, want.last, m_axis_tdata[3:0],
                                 m_axis_tdata[35:4], m_axis_tdata[39:36], m_axis_tlast);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // predictor
    //------------------------------------------------------------------
    function automatic void push_result(logic [3:0] tag, logic [31:0] word);
        bpb_result_t r;
        r.tag  = tag;
        r.word = word;
        r.last = 1'b0;
        bpb_expected_q.push_back(r);
    endfunction

    function automatic void mark_last();
        bpb_result_t r;
        r = bpb_expected_q.pop_back();
        r.last = 1'b1;
        bpb_expected_q.push_back(r);
    endfunction

    function automatic logic [31:0] le_word(int off, int n);
        logic [31:0] v;
        v = '0;
        for (int i = n - 1; i >= 0; i--)
            v = {v[23:0], cap_img[off + i]};
        return v;
    endfunction

    // work out the result run once offset 511 is in
    function automatic void predict_sector();
        longint unsigned fat_sz, tot, dir_sectors, dir_start, heap_start, clusters;
        logic [15:0] sec_size, rsv, root_ent, tot16, fat16, fsinfo;
        logic [7:0]  clus, copies, ch;
        logic [31:0] tot32, fat32, root_clu, status, fs_type;
        int base, len;
        sec_size = 16'(le_word(11, 2));
        clus     = cap_img[13];
        rsv      = 16'(le_word(14, 2));
        copies   = cap_img[16];
        root_ent = 16'(le_word(17, 2));
        tot16    = 16'(le_word(19, 2));
        fat16    = 16'(le_word(22, 2));
        tot32    = le_word(32, 4);
        fat32    = le_word(36, 4);
        root_clu = le_word(44, 4);
        fsinfo   = 16'(le_word(48, 2));

        fat_sz      = (fat16 != 16'd0) ? 64'(fat16) : 64'(fat32);
        tot         = (tot16 != 16'd0) ? 64'(tot16) : 64'(tot32);
        dir_sectors = (64'(root_ent) * 64'd32 + 64'd511) / 64'd512;
        dir_start   = 64'(rsv) + 64'(copies) * fat_sz;
        heap_start  = dir_start + dir_sectors;

        if (cap_img[510] != 8'h55 || cap_img[511] != 8'hAA)
            status = ST_SIG;
        else if (sec_size != 16'd512 || clus == 8'd0 || copies == 8'd0)
            status = ST_FIELDS;
        else if (fat_sz == 0 || tot == 0)
            status = ST_ZERO;
        else if (tot <= heap_start)
            status = ST_NODATA;
        else
            status = ST_OK;

        push_result(TAG_STATUS, status);
        if (status != ST_OK) begin
            mark_last();
            return;
        end

        clusters = (tot - heap_start) / 64'(clus);
        fs_type  = (clusters < 64'd4085) ? 32'd12 : (clusters < 64'd65525) ? 32'd16 : 32'd32;
        push_result(TAG_TYPE, fs_type);
        push_result(TAG_CLUS, {24'd0, clus});
        push_result(TAG_FATS, {24'd0, copies});
        push_result(TAG_FAT_LBA, {16'd0, rsv});
        push_result(TAG_FAT_SIZE, fat_sz[31:0]);
        push_result(TAG_ROOT_LBA, dir_start[31:0]);
        push_result(TAG_ROOT_SEC, dir_sectors[31:0]);
        push_result(TAG_DATA_LBA, heap_start[31:0]);
        push_result(TAG_CLUSTERS, clusters[31:0]);
        if (fs_type == 32'd32) begin
            push_result(TAG_ROOT_CLU, root_clu);
            push_result(TAG_FSINFO, {16'd0, fsinfo});
        end

        // trailing spaces go first, then the label stops at its first NUL
        base = (fs_type == 32'd32) ? 71 : 43;
        len  = LABEL_LEN;
        while (len > 0 && cap_img[base + len - 1] == 8'h20)
            len--;
        for (int i = 0; i < len; i++)
            if (cap_img[base + i] == 8'h00) begin
                len = i;
                break;
            end
        push_result(TAG_LBL_LEN, 32'(len));
        for (int i = 0; i < len; i++) begin
            ch = cap_img[base + i];
            if (ch >= 8'h41 && ch <= 8'h5A)
                ch = ch + 8'h20;
            push_result(TAG_LBL_CHR, {24'd0, ch});
        end
        mark_last();
    endfunction

    //------------------------------------------------------------------
    // stimulus helpers
    //------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        // accepted at this edge
        cap_img[cap_pos] = b;
        bytes_sent = bytes_sent + 1;
        if (cap_pos == 511) begin
            predict_sector();
            cap_pos = 0;
            sectors_sent = sectors_sent + 1;
        end else begin
            cap_pos = cap_pos + 1;
        end
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (bpb_expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void put_le(int off, int n, logic [31:0] v);
        for (int i = 0; i < n; i++)
            sect[off + i] = v[8 * i +: 8];
    endfunction

    function automatic logic [7:0] label_char();
        unique case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            2:       return 8'($urandom_range(8'h61, 8'h7A));
            3:       return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h40;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // build a well-formed sector of the given type with a random label
    function automatic void make_sector(sector_kind_t kind);
        longint unsigned clus, copies, rsv, root_ent, fat, dir_sectors, heap, target, tot;
        for (int i = 0; i < 512; i++)
            sect[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < LABEL_LEN; i++) begin
            sect[43 + i] = label_char();
            sect[71 + i] = label_char();
        end

        clus        = 64'd1 << $urandom_range(0, 7);
        copies      = $urandom_range(1, 2);
        rsv         = $urandom_range(1, 64);
        root_ent    = $urandom_range(0, 4096);
        fat         = (kind == SK_FAT32) ? $urandom_range(1, 100000) : $urandom_range(1, 300);
        dir_sectors = (root_ent * 32 + 511) / 512;
        heap        = rsv + copies * fat + dir_sectors;
        unique case (kind)
            SK_FAT12: target = $urandom_range(1, 4084);
            SK_FAT16: target = $urandom_range(4085, 65524);
            default:  target = $urandom_range(65525, 4000000);
        endcase
        tot = heap + target * clus + $urandom_range(0, 32'(clus - 1));

        put_le(11, 2, 32'd512);
        sect[13] = 8'(clus);
        put_le(14, 2, 32'(rsv));
        sect[16] = 8'(copies);
        put_le(17, 2, 32'(root_ent));
        if (kind == SK_FAT32) begin
            put_le(22, 2, 32'd0);
            put_le(36, 4, 32'(fat));
        end else begin
            put_le(22, 2, 32'(fat));
        end
        if (tot < 65536 && $urandom_range(0, 1)) begin
            put_le(19, 2, 32'(tot));
        end else begin
            put_le(19, 2, 32'd0);
            put_le(32, 4, 32'(tot));
        end
        sect[510] = 8'h55;
        sect[511] = 8'hAA;
    endfunction

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------
    // most of a FAT32 sector with random gaps on the input side
    task automatic test_capture_gaps();
        make_sector(SK_FAT32);
        for (int i = 0; i < HOLD_FROM; i++)
            send_byte(sect[i]);
    endtask

    // long receiver hold-off: the run backs up and blocks the next sector's bytes
    task automatic test_stall_full();
        quiet = 1'b1;
        hold_go <= 1'b1;
        send_byte(sect[HOLD_FROM]);
        hold_go <= 1'b0;
        for (int i = HOLD_FROM + 1; i < 512; i++)
            send_byte(sect[i]);
        make_sector(SK_FAT16);
        for (int i = 0; i < TAIL_BYTES; i++)
            send_byte(sect[i]);
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;
    endtask

    // sender waits for every result, then input resumes
    task automatic test_pause_drain();
        wait_drained();
        for (int i = TAIL_BYTES; i < TAIL_BYTES + 4; i++)
            send_byte(sect[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    //------------------------------------------------------------------
    // main sequence
    //------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        hold_go       = 1'b0;
        bytes_sent    = 0;
        sectors_sent  = 0;
        cap_pos       = 0;
        quiet         = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_capture_gaps();
        test_stall_full();
        test_pause_drain();

        wait_drained();
        $display("Sent %0d sectors (%0d bytes), checked %0d result beats",
                 sectors_sent, bytes_sent, beats_seen);
        $display("Covered a FAT32 sector with random idling, a long output stall that %s",
                 "blocked input, and a full drain before input resumed");
        if (mismatches == 0 && bpb_expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
